FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the signature block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define MCS_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted
`define MCS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

FILE: src/mcs_pkg.sv
// ----------------------------------------------------------------------------
// mcs_pkg
// Constants, command codes and core handshake structs for the multiset
// signature block.
// ----------------------------------------------------------------------------
package mcs_pkg;

  // Lane init constants (scaled by key on reload)
  localparam logic [63:0] LANE0_SEED  = 64'hC4D7_15A7_1586_1702;
  localparam logic [63:0] LANE1_SEED  = 64'hB767_9773_56C4_9687;

  // Finalizer and combine constants
  localparam logic [63:0] FMIX_MUL_A  = 64'hff51_afd7_ed55_8ccd;
  localparam logic [63:0] FMIX_MUL_B  = 64'hc4ce_b9fe_1a85_ec53;
  localparam logic [63:0] GOLDEN_ADD  = 64'h0000_0000_9e37_79b9;
  localparam int unsigned FMIX_SHIFT  = 33;

  localparam logic [63:0] KEY_RESET   = 64'd1;

  // Command codes
  localparam logic [1:0] CMD_ABSORB = 2'd0;
  localparam logic [1:0] CMD_CLOSE  = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // Request into the core: one accepted input word
  typedef struct packed {
    logic        start;
    logic [1:0]  command;
    logic [63:0] word;
  } core_req_t;

  // Core status back to the top level
  typedef struct packed {
    logic idle;
    logic done;
  } core_stat_t;

endpackage

FILE: src/mcs_if.sv
// ----------------------------------------------------------------------------
// mcs_if
// Valid/ready channel interfaces for input words and signature results.
// ----------------------------------------------------------------------------

// Input channel: command plus 64-bit word
interface mcs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [63:0] word;

  modport source (output valid, output command, output word, input ready);
  modport sink   (input valid, input command, input word, output ready);
endinterface

// Output channel: both lane signatures
interface mcs_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] lane0_sig;
  logic [63:0] lane1_sig;

  modport source (output valid, output lane0_sig, output lane1_sig,
                  input ready);
  modport sink   (input valid, input lane0_sig, input lane1_sig,
                  output ready);
endinterface

FILE: src/mcs_mul.sv
// ----------------------------------------------------------------------------
// mcs_mul
// Shared 32x32 unsigned multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module mcs_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] a_ext;
  logic [63:0] b_ext;
  logic [63:0] p_d;
  logic [63:0] p_q;

  // Full 64-bit product of two 32-bit operands
  assign a_ext = {32'd0, a_i};
  assign b_ext = {32'd0, b_i};
  assign p_d   = a_ext * b_ext;

  // Product register
  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

FILE: src/mcs_core.sv
// ----------------------------------------------------------------------------
// mcs_core
// Sequencer and datapath: finalizer, lane combine, squaring and reload,
// with every 64-bit multiply built from three 32x32 partial products.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mcs_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mcs_pkg::core_req_t  req_i,
  input  logic [63:0]         key_i,
  input  logic                hold_i,
  output mcs_pkg::core_stat_t stat_o,
  output logic [63:0]         first_sum_o,
  output logic [63:0]         second_sum_o
);

  // Sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_FIN   = 3'd2;
  localparam logic [2:0] ST_GOLD  = 3'd3;
  localparam logic [2:0] ST_COMB0 = 3'd4;
  localparam logic [2:0] ST_COMB1 = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  // Which 64-bit multiply is in flight
  localparam logic [2:0] JOB_FMIX_A = 3'd0;
  localparam logic [2:0] JOB_FMIX_B = 3'd1;
  localparam logic [2:0] JOB_SQ0    = 3'd2;
  localparam logic [2:0] JOB_SQ1    = 3'd3;
  localparam logic [2:0] JOB_RL0    = 3'd4;
  localparam logic [2:0] JOB_RL1    = 3'd5;

  logic [2:0]  state_q, state_d;
  logic [1:0]  phase_q, phase_d;
  logic [2:0]  job_q, job_d;
  logic        close_q, close_d;
  logic        clear_q, clear_d;
  logic [63:0] op_a_q, op_a_d;
  logic [63:0] op_b_q, op_b_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] mix_q, mix_d;
  logic [63:0] lane0_q, lane0_d;
  logic [63:0] lane1_q, lane1_d;
  logic [63:0] sum0_q, sum0_d;
  logic [63:0] sum1_q, sum1_d;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;

  // Finalizer xor-shift step
  function automatic logic [63:0] xs(input logic [63:0] v);
    xs = v ^ (v >> mcs_pkg::FMIX_SHIFT);
  endfunction

  // Boost-style combine; f already carries the golden constant
  function automatic logic [63:0] comb(input logic [63:0] s, input logic [63:0] f);
    comb = s ^ (f + {s[57:0], 6'd0} + {2'd0, s[63:2]});
  endfunction

  // Partial product order: lo*lo, lo(a)*hi(b), hi(a)*lo(b)
  assign mul_a = (phase_q == 2'd2) ? op_a_q[63:32] : op_a_q[31:0];
  assign mul_b = (phase_q == 2'd1) ? op_b_q[63:32] : op_b_q[31:0];

  mcs_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // Next-state and datapath
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    job_d   = job_q;
    close_d = close_q;
    clear_d = clear_q;
    op_a_d  = op_a_q;
    op_b_d  = op_b_q;
    acc_d   = acc_q;
    mix_d   = mix_q;
    lane0_d = lane0_q;
    lane1_d = lane1_q;
    sum0_d  = sum0_q;
    sum1_d  = sum1_q;

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.start) begin
          close_d = (req_i.command == mcs_pkg::CMD_CLOSE);
          clear_d = (req_i.command == mcs_pkg::CMD_CLEAR);
          priority if (req_i.command == mcs_pkg::CMD_ABSORB ||
                       req_i.command == mcs_pkg::CMD_CLOSE) begin
            op_a_d  = xs(req_i.word);
            op_b_d  = mcs_pkg::FMIX_MUL_A;
            job_d   = JOB_FMIX_A;
            state_d = ST_MUL;
          end else if (req_i.command == mcs_pkg::CMD_CLEAR) begin
            op_a_d  = mcs_pkg::LANE0_SEED;
            op_b_d  = key_i;
            job_d   = JOB_RL0;
            state_d = ST_MUL;
          end else begin
            state_d = ST_OUT;
          end
        end
      end

      // Issue, then accumulate three partial products
      ST_MUL: begin
        phase_d = phase_q + 2'd1;
        unique case (phase_q)
          2'd0: acc_d = acc_q;
          2'd1: acc_d = prod;
          2'd2: acc_d = acc_q + {prod[31:0], 32'd0};
          2'd3: begin
            acc_d   = acc_q + {prod[31:0], 32'd0};
            state_d = ST_FIN;
          end
          default: acc_d = acc_q;
        endcase
      end

      // acc_q holds the finished product
      ST_FIN: begin
        unique case (job_q)
          JOB_FMIX_A: begin
            op_a_d  = xs(acc_q);
            op_b_d  = mcs_pkg::FMIX_MUL_B;
            job_d   = JOB_FMIX_B;
            state_d = ST_MUL;
          end
          JOB_FMIX_B: begin
            mix_d   = xs(acc_q);
            state_d = ST_GOLD;
          end
          JOB_SQ0: begin
            sum0_d  = sum0_q + acc_q;
            op_a_d  = lane1_q;
            op_b_d  = lane1_q;
            job_d   = JOB_SQ1;
            state_d = ST_MUL;
          end
          JOB_SQ1: begin
            sum1_d  = sum1_q + acc_q;
            op_a_d  = mcs_pkg::LANE0_SEED;
            op_b_d  = key_i;
            job_d   = JOB_RL0;
            state_d = ST_MUL;
          end
          JOB_RL0: begin
            lane0_d = acc_q;
            if (clear_q) begin
              sum0_d = acc_q;
            end
            op_a_d  = mcs_pkg::LANE1_SEED;
            op_b_d  = key_i;
            job_d   = JOB_RL1;
            state_d = ST_MUL;
          end
          JOB_RL1: begin
            lane1_d = acc_q;
            if (clear_q) begin
              sum1_d = acc_q;
            end
            state_d = ST_OUT;
          end
          default: state_d = ST_OUT;
        endcase
      end

      ST_GOLD: begin
        mix_d   = mix_q + mcs_pkg::GOLDEN_ADD;
        state_d = ST_COMB0;
      end

      ST_COMB0: begin
        lane0_d = comb(lane0_q, mix_q);
        state_d = ST_COMB1;
      end

      // Second lane combine; start squaring on close
      ST_COMB1: begin
        lane1_d = comb(lane1_q, mix_q);
        if (close_q) begin
          op_a_d  = lane0_q;
          op_b_d  = lane0_q;
          job_d   = JOB_SQ0;
          state_d = ST_MUL;
        end else begin
          state_d = ST_OUT;
        end
      end

      // Wait for the output register to take the sums
      ST_OUT: begin
        if (!hold_i) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= 2'd0;
      job_q   <= JOB_FMIX_A;
      close_q <= 1'b0;
      clear_q <= 1'b0;
      lane0_q <= mcs_pkg::LANE0_SEED;
      lane1_q <= mcs_pkg::LANE1_SEED;
      sum0_q  <= mcs_pkg::LANE0_SEED;
      sum1_q  <= mcs_pkg::LANE1_SEED;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      job_q   <= job_d;
      close_q <= close_d;
      clear_q <= clear_d;
      lane0_q <= lane0_d;
      lane1_q <= lane1_d;
      sum0_q  <= sum0_d;
      sum1_q  <= sum1_d;
    end
  end

  // Operand and scratch registers
  always_ff @(posedge clk_i) begin
    op_a_q <= op_a_d;
    op_b_q <= op_b_d;
    acc_q  <= acc_d;
    mix_q  <= mix_d;
  end

  assign stat_o.idle  = (state_q == ST_IDLE);
  assign stat_o.done  = (state_q == ST_OUT) && !hold_i;
  assign first_sum_o  = sum0_q;
  assign second_sum_o = sum1_q;

  // Checks
  `MCS_ASSERT_IMPL(a_phase_only_in_mul, clk_i, rst_ni, state_q != ST_MUL, phase_q == 2'd0)
  `MCS_ASSERT_NEXT(a_start_leaves_idle, clk_i, rst_ni, req_i.start && stat_o.idle, !stat_o.idle)
  `MCS_ASSERT_NEXT(a_done_returns_idle, clk_i, rst_ni, stat_o.done, state_q == ST_IDLE)
  `MCS_ASSERT_NEXT(a_sums_hold_mul, clk_i, rst_ni, state_q == ST_MUL, $stable({sum0_q, sum1_q}))

endmodule

FILE: src/multiset_clause_signature_top.sv
// ----------------------------------------------------------------------------
// multiset_clause_signature_top
// Order-independent 128-bit signature over objects of 64-bit words.
//
//   Port         Dir   Payload                               Handshake
//   in_i         in    command[1:0], word[63:0]              valid/ready
//   out_o        out   lane0_sig[63:0], lane1_sig[63:0]      valid/ready
//   key_*_i      in    key_wdata_i[63:0]                     key_we_i
//
// One word at a time through a single 32x32 multiplier; the core returns to
// idle as the result loads into the output register and only then takes the
// next word.
// Reset is asynchronous, active low; key returns to 1 and lanes/sums to their
// init constants, with no clearing pass.
// A stalled result sits in the output register while the next word is taken;
// a new result waits until that register is free.
// ----------------------------------------------------------------------------
module multiset_clause_signature_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  mcs_in_if.sink      in_i,
  mcs_out_if.source   out_o,
  input  logic        key_we_i,
  input  logic [63:0] key_wdata_i
);

  logic [63:0]         key_q;
  logic                out_valid_q;
  logic [63:0]         out_first_q;
  logic [63:0]         out_second_q;
  logic                hold;
  mcs_pkg::core_req_t  req;
  mcs_pkg::core_stat_t stat;
  logic [63:0]         first_sum;
  logic [63:0]         second_sum;

  // Key register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= mcs_pkg::KEY_RESET;
    end else if (key_we_i) begin
      key_q <= key_wdata_i;
    end
  end

  // Input word into the core
  assign in_i.ready  = stat.idle;
  assign req.start   = in_i.valid && stat.idle;
  assign req.command = in_i.command;
  assign req.word    = in_i.word;

  // Output register full and not draining
  assign hold = out_valid_q && !out_o.ready;

  mcs_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req),
    .key_i        (key_q),
    .hold_i       (hold),
    .stat_o       (stat),
    .first_sum_o  (first_sum),
    .second_sum_o (second_sum)
  );

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stat.done) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (stat.done) begin
      out_first_q  <= first_sum;
      out_second_q <= second_sum;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.lane0_sig = out_first_q;
  assign out_o.lane1_sig = out_second_q;

endmodule

FILE: test/mcs_sig_checker.sv
// ----------------------------------------------------------------------------
// mcs_sig_checker
// Watches the word and signature channels of the multiset signature block,
// predicts both lane sums for every accepted word and compares each accepted
// result against the oldest prediction still due.
// ----------------------------------------------------------------------------
module mcs_sig_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  mcs_in_if           in_bus,
  mcs_out_if          out_bus,
  input  logic        key_we_i,
  input  logic [63:0] key_wdata_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic [63:0] first_sig;
    logic [63:0] second_sig;
  } sig_pair_t;

  // Shadow copy of the key register and both lanes
  logic [63:0] key_q;
  logic [63:0] first_state, second_state;
  logic [63:0] first_sum, second_sum;

  // Signature pairs still owed by the block, oldest first
  sig_pair_t sums_due[$];

  // murmur3 64-bit finalizer
  function automatic logic [63:0] fmix_word(input logic [63:0] v);
    logic [63:0] h;
    h = v;
    h = h ^ (h >> mcs_pkg::FMIX_SHIFT);
    h = h * mcs_pkg::FMIX_MUL_A;
    h = h ^ (h >> mcs_pkg::FMIX_SHIFT);
    h = h * mcs_pkg::FMIX_MUL_B;
    h = h ^ (h >> mcs_pkg::FMIX_SHIFT);
    return h;
  endfunction

  // boost-style hash combine of one word into a lane state
  function automatic logic [63:0] fold_word(input logic [63:0] s, input logic [63:0] w);
    return s ^ (fmix_word(w) + mcs_pkg::GOLDEN_ADD + (s << 6) + (s >> 2));
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    fail_count_o = fail_count_o + 1;
  endtask

  // Predict on accepted words, compare on accepted results
  always @(posedge clk_i or negedge rst_ni) begin
    sig_pair_t due;
    if (!rst_ni) begin
      key_q        = mcs_pkg::KEY_RESET;
      first_state  = mcs_pkg::LANE0_SEED * mcs_pkg::KEY_RESET;
      second_state = mcs_pkg::LANE1_SEED * mcs_pkg::KEY_RESET;
      first_sum    = first_state;
      second_sum   = second_state;
      sums_due.delete();
      fail_count_o = 0;
      pending_o   <= 0;
    end else begin
      // result side first: it never belongs to a word taken at this edge
      if (out_bus.valid && out_bus.ready) begin
        if (sums_due.size() == 0) begin
          report_mismatch("result with no word pending", out_bus.lane0_sig, '0);
        end else begin
          due = sums_due.pop_front();
          if (out_bus.lane0_sig !== due.first_sig)
            report_mismatch("lane0_sig", out_bus.lane0_sig, due.first_sig);
          if (out_bus.lane1_sig !== due.second_sig)
            report_mismatch("lane1_sig", out_bus.lane1_sig, due.second_sig);
        end
      end

      if (in_bus.valid && in_bus.ready) begin
        case (in_bus.command)
          mcs_pkg::CMD_ABSORB, mcs_pkg::CMD_CLOSE: begin
            first_state  = fold_word(first_state, in_bus.word);
            second_state = fold_word(second_state, in_bus.word);
            if (in_bus.command == mcs_pkg::CMD_CLOSE) begin
              first_sum    = first_sum + first_state * first_state;
              second_sum   = second_sum + second_state * second_state;
              first_state  = mcs_pkg::LANE0_SEED * key_q;
              second_state = mcs_pkg::LANE1_SEED * key_q;
            end
          end
          mcs_pkg::CMD_CLEAR: begin
            first_state  = mcs_pkg::LANE0_SEED * key_q;
            second_state = mcs_pkg::LANE1_SEED * key_q;
            first_sum    = first_state;
            second_sum   = second_state;
          end
          default: begin
            // unused code: state untouched, sums still reported
          end
        endcase
        due.first_sig  = first_sum;
        due.second_sig = second_sum;
        sums_due.push_back(due);
      end

      // key only matters at the next reload
      if (key_we_i)
        key_q = key_wdata_i;

      pending_o <= sums_due.size();
    end
  end

endmodule

FILE: test/tb_multiset_clause_signature_top.sv
// ----------------------------------------------------------------------------
// tb_multiset_clause_signature_top
// Drives the multiset signature block with directed and random word streams
// under several key settings, with random gaps on the word side and random
// stalls on the result side. Checking is done by mcs_sig_checker.
// ----------------------------------------------------------------------------
module tb_multiset_clause_signature_top;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 1450;
  localparam int unsigned PHASES = 6;

  logic        clk_i;
  logic        rst_ni;
  logic        key_we;
  logic [63:0] key_wdata;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned words_sent;
  logic        calm;

  mcs_in_if  word_bus ();
  mcs_out_if sig_bus ();

  multiset_clause_signature_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (word_bus),
    .out_o       (sig_bus),
    .key_we_i    (key_we),
    .key_wdata_i (key_wdata)
  );

  mcs_sig_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_bus       (word_bus),
    .out_bus      (sig_bus),
    .key_we_i     (key_we),
    .key_wdata_i  (key_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Clock
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Idle length: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Word values biased toward the edges
  function automatic logic [63:0] pick_word();
    logic [63:0] one_hot;
    one_hot = 64'd1 << $urandom_range(0, 63);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return one_hot;
      3: return ~one_hot;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Present one word and hold it until taken; valid stays high afterwards
  task automatic send_word(input logic [1:0] cmd, input logic [63:0] w);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      word_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    word_bus.valid   <= 1'b1;
    word_bus.command <= cmd;
    word_bus.word    <= w;
    @(posedge clk_i);
    while (!word_bus.ready) @(posedge clk_i);
    words_sent = words_sent + 1;
  endtask

  // Stop sending and wait until every result has come back
  task automatic drain();
    word_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Key write only while the block is idle
  task automatic write_key(input logic [63:0] v);
    drain();
    repeat (4) @(posedge clk_i);
    key_we    <= 1'b1;
    key_wdata <= v;
    @(posedge clk_i);
    key_we    <= 1'b0;
  endtask

  // One object of random length, sometimes cut off by a clear
  task automatic send_object(input int unsigned len, input bit broken);
    for (int unsigned i = 1; i < len; i++)
      send_word(mcs_pkg::CMD_ABSORB, pick_word());
    if (broken)
      send_word(mcs_pkg::CMD_CLEAR, pick_word());
    else
      send_word(mcs_pkg::CMD_CLOSE, pick_word());
  endtask

  // Result side: random stalls
  initial begin
    int unsigned stall;
    sig_bus.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        sig_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      sig_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  // Stimulus and verdict
  initial begin
    int unsigned r;
    int unsigned target;
    logic [63:0] phase_key;
    rst_ni           <= 1'b0;
    key_we           <= 1'b0;
    key_wdata        <= '0;
    word_bus.valid   <= 1'b0;
    word_bus.command <= mcs_pkg::CMD_ABSORB;
    word_bus.word    <= '0;
    words_sent = 0;
    calm = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset key, field extremes, every command
    send_word(mcs_pkg::CMD_ABSORB, '0);
    send_word(mcs_pkg::CMD_ABSORB, '1);
    send_word(mcs_pkg::CMD_CLOSE, '0);
    send_word(CMD_UNUSED, {$urandom, $urandom});
    send_word(mcs_pkg::CMD_CLOSE, '1);
    send_word(mcs_pkg::CMD_CLEAR, '1);
    send_word(mcs_pkg::CMD_CLOSE, 64'h8000_0000_0000_0000);
    send_word(mcs_pkg::CMD_ABSORB, 64'h5555_5555_5555_5555);
    // key changed with an object open: old lane state carries on
    write_key('0);
    send_word(mcs_pkg::CMD_CLOSE, 64'hAAAA_AAAA_AAAA_AAAA);
    send_word(mcs_pkg::CMD_CLOSE, 64'd1);
    send_word(CMD_UNUSED, '0);
    send_word(mcs_pkg::CMD_CLEAR, '0);
    send_word(mcs_pkg::CMD_ABSORB, '1);
    write_key('1);
    send_word(mcs_pkg::CMD_CLOSE, '0);
    send_word(mcs_pkg::CMD_ABSORB, 64'd1);
    send_word(mcs_pkg::CMD_CLOSE, '1);
    send_word(mcs_pkg::CMD_CLEAR, '0);
    send_word(CMD_UNUSED, '1);
    write_key({$urandom, $urandom});
    send_word(mcs_pkg::CMD_CLOSE, {$urandom, $urandom});
    send_word(mcs_pkg::CMD_CLEAR, '0);
    send_word(mcs_pkg::CMD_CLOSE, '1);

    // random phases, each under its own key
    for (int unsigned p = 0; p < PHASES; p++) begin
      case (p)
        0: phase_key = mcs_pkg::KEY_RESET;
        1: phase_key = '0;
        2: phase_key = '1;
        default: phase_key = {$urandom, $urandom};
      endcase
      write_key(phase_key);
      calm = (p == 3);
      target = words_sent + RANDOM_ITEMS / PHASES;
      while (words_sent < target) begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          send_word(mcs_pkg::CMD_CLEAR, pick_word());
        end else if (r < 7) begin
          send_word(CMD_UNUSED, pick_word());
        end else if (r < 12) begin
          send_object($urandom_range(1, 6), 1'b1);
        end else if (r < 18) begin
          send_object($urandom_range(7, 20), 1'b0);
        end else begin
          send_object($urandom_range(1, 6), 1'b0);
        end
      end
    end
    calm = 1'b0;

    drain();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // Watchdog
  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
